// ----- hw/rtl/spq_pkg.sv -----
package spq_pkg;

    // Default sizes
    localparam int DEF_PRIORITY_LEVELS = 8;
    localparam int DEF_QUEUE_DEPTH     = 16;
    localparam int DEF_TAG_WIDTH       = 16;
    localparam int DEF_MAX_SEND        = 32;

    // Fixed field widths
    localparam int PRIO_W = 3;
    localparam int SEND_W = 6;
    localparam int QLEN_W = 4;

    localparam logic [QLEN_W-1:0] QLEN_RESET = 4'd15;

    // Input item kind, carried in tuser
    localparam logic ACT_RECEIVE = 1'b0;
    localparam logic ACT_SEND    = 1'b1;

endpackage

// ----- hw/rtl/spq_tag_ram.sv -----
module spq_tag_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 128
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [DATA_W-1:0]          i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [DATA_W-1:0]          o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/strict_priority_packet_queue.sv -----
// Channel    | Dir | Handshake                       | Payload
// s_axis     | in  | i_s_axis_tvalid/o_s_axis_tready | tdata: priority_req, packet_tag,
//            |     |                                 |   send_count; tuser: action
// m_axis     | out | o_m_axis_tvalid/i_m_axis_tready | tdata: out_tag, out_priority;
//            |     |                                 |   tlast: last
// cfg        | in  | i_cfg_wr_en                     | i_cfg_wr_data: max_queue_len
//
// A compaction copies one tag per cycle through the single read and write port of the
// tag RAM, reading entry 2i and then writing it to entry i. Each packet of a send passes
// a RAM read (PICK), then an output register load (DATA); PICK waits while the output
// register is full and not taken. A send that emits nothing leaves the queue idle.
// Reset clears all queue counts and heads and sets max_queue_len to 15; the tag
// RAM is not cleared. New input is taken only between items, but the last
// result may still sit in the output register while the next item is taken.
module strict_priority_packet_queue #(
    parameter int PRIORITY_LEVELS = spq_pkg::DEF_PRIORITY_LEVELS,
    parameter int QUEUE_DEPTH     = spq_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_WIDTH       = spq_pkg::DEF_TAG_WIDTH,
    parameter int MAX_SEND        = spq_pkg::DEF_MAX_SEND
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // slave stream
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // tdata, low to high: priority_req, packet_tag, send_count, zero fill
    input  logic [((spq_pkg::PRIO_W+TAG_WIDTH+spq_pkg::SEND_W+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: action
    input  logic i_s_axis_tuser,

    // master stream
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // tdata, low to high: out_tag, out_priority, zero fill
    output logic [((TAG_WIDTH+spq_pkg::PRIO_W+7)/8)*8-1:0] o_m_axis_tdata,
    output logic o_m_axis_tlast,

    // configuration
    input  logic                        i_cfg_wr_en,
    input  logic [spq_pkg::QLEN_W-1:0]  i_cfg_wr_data
);

    import spq_pkg::*;

    localparam int LVL_W      = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int SLOT_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_DEPTH  = PRIORITY_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);
    localparam int REM_W      = $clog2(MAX_SEND + 1);
    localparam int OUT_DATA_W = ((TAG_WIDTH + PRIO_W + 7) / 8) * 8;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CMPCT = 4'b0010,
        ST_PICK  = 4'b0100,
        ST_DATA  = 4'b1000
    } t_state;

    // (base + off) mod QUEUE_DEPTH, with base + off < 2 * QUEUE_DEPTH
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                   input logic [SLOT_W:0]   off);
        logic [SLOT_W+1:0] sum;
        sum = {2'b00, base} + {1'b0, off};
        if (sum >= (SLOT_W+2)'(QUEUE_DEPTH)) begin
            sum = sum - (SLOT_W+2)'(QUEUE_DEPTH);
        end
        return sum[SLOT_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] ram_addr(input logic [LVL_W-1:0]  lvl,
                                                   input logic [SLOT_W-1:0] slot);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH);
        return base + ADDR_W'(slot);
    endfunction

    // ---------------- state ----------------
    t_state                r_state, n_state;
    logic [QLEN_W-1:0]     r_max_len;
    logic [CNT_W-1:0]      r_count [PRIORITY_LEVELS];
    logic [SLOT_W-1:0]     r_head  [PRIORITY_LEVELS];

    // compaction walk
    logic [LVL_W-1:0]      r_clvl;
    logic [SLOT_W-1:0]     r_chead;
    logic [CNT_W-1:0]      r_keep;
    logic [CNT_W-1:0]      r_ci;
    logic                  r_cpend;
    logic [SLOT_W-1:0]     r_cwslot;

    // send
    logic [REM_W-1:0]      r_remain;
    logic [LVL_W-1:0]      r_pick_lvl;
    logic                  r_pick_last;

    // output register
    logic                  r_out_valid;
    logic [TAG_WIDTH-1:0]  r_out_tag;
    logic [PRIO_W-1:0]     r_out_prio;
    logic                  r_out_last;

    // ---------------- input decode ----------------
    logic                  in_xfer;
    logic                  in_action;
    logic [PRIO_W-1:0]     in_prio;
    logic [TAG_WIDTH-1:0]  in_tag;
    logic [SEND_W-1:0]     in_want;
    logic [LVL_W-1:0]      in_lvl;
    logic [REM_W-1:0]      want_sat;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer   = i_s_axis_tvalid && o_s_axis_tready;
    assign in_action = i_s_axis_tuser;
    assign in_prio   = i_s_axis_tdata[PRIO_W-1:0];
    assign in_tag    = i_s_axis_tdata[PRIO_W +: TAG_WIDTH];
    assign in_want   = i_s_axis_tdata[PRIO_W+TAG_WIDTH +: SEND_W];
    assign in_lvl    = LVL_W'(in_prio);
    assign want_sat  = (32'(in_want) > MAX_SEND) ? REM_W'(MAX_SEND) : REM_W'(in_want);

    // ---------------- level scan ----------------
    logic [PRIORITY_LEVELS-1:0] nonempty;
    logic [PRIORITY_LEVELS-1:0] nonempty_after;
    logic [LVL_W-1:0]           top_lvl;

    always_comb begin
        top_lvl = '0;
        for (int l = 0; l < PRIORITY_LEVELS; l++) begin
            nonempty[l] = (r_count[l] != '0);
            if (nonempty[l]) begin
                top_lvl = LVL_W'(l);
            end
        end
    end

    // one shared lookup of count/head: the top level while sending, else the input level
    logic [LVL_W-1:0]  sel_lvl;
    logic [CNT_W-1:0]  cnt_sel;
    logic [SLOT_W-1:0] head_sel;

    assign sel_lvl  = (r_state == ST_PICK) ? top_lvl : in_lvl;
    assign cnt_sel  = r_count[sel_lvl];
    assign head_sel = r_head[sel_lvl];

    always_comb begin
        nonempty_after = nonempty;
        if (cnt_sel == CNT_W'(1)) begin
            nonempty_after[top_lvl] = 1'b0;
        end
    end

    // ---------------- receive ----------------
    logic             rcv_ok;
    logic [CNT_W:0]   rcv_cnt;
    logic             rcv_cmp;
    logic [CNT_W-1:0] rcv_keep;
    logic [CNT_W:0]   rcv_cnt_p1;

    assign rcv_ok     = in_xfer && (in_action == ACT_RECEIVE)
                        && (32'(in_prio) < PRIORITY_LEVELS)
                        && (32'(cnt_sel) < QUEUE_DEPTH);
    assign rcv_cnt    = {1'b0, cnt_sel} + (CNT_W+1)'(1);
    assign rcv_cnt_p1 = rcv_cnt + (CNT_W+1)'(1);
    assign rcv_keep   = CNT_W'(rcv_cnt_p1 >> 1);
    assign rcv_cmp    = 32'(rcv_cnt) > 32'(r_max_len);

    // ---------------- send ----------------
    logic out_free;
    logic pick_go;
    logic pick_last;

    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign pick_go   = (r_state == ST_PICK) && out_free;
    assign pick_last = (r_remain == REM_W'(1)) || (nonempty_after == '0);

    // ---------------- compaction ----------------
    logic c_step;
    assign c_step = (r_state == ST_CMPCT) && (r_ci < r_keep);

    // ---------------- tag RAM ----------------
    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [TAG_WIDTH-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [ADDR_W-1:0]    ram_rd_addr;
    logic [TAG_WIDTH-1:0] ram_rd_data;

    always_comb begin
        // write: pending compaction copy, else the received tag at the tail
        ram_wr_en   = r_cpend || rcv_ok;
        ram_wr_addr = ram_addr(in_lvl, slot_add(head_sel, (SLOT_W+1)'(cnt_sel)));
        ram_wr_data = in_tag;
        if (r_cpend) begin
            ram_wr_addr = ram_addr(r_clvl, r_cwslot);
            ram_wr_data = ram_rd_data;
        end

        // read: entry 2i during compaction, else the head of the top level
        ram_rd_en   = c_step || pick_go;
        ram_rd_addr = ram_addr(top_lvl, head_sel);
        if (r_state == ST_CMPCT) begin
            ram_rd_addr = ram_addr(r_clvl,
                                   slot_add(r_chead, (SLOT_W+1)'({r_ci, 1'b0})));
        end
    end

    spq_tag_ram #(
        .DATA_W (TAG_WIDTH),
        .DEPTH  (RAM_DEPTH)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (rcv_ok && rcv_cmp) begin
                    n_state = ST_CMPCT;
                end else if (in_xfer && (in_action == ACT_SEND)
                             && (want_sat != '0) && (nonempty != '0)) begin
                    n_state = ST_PICK;
                end
            end
            ST_CMPCT: begin
                // leave once every copy is issued and the last write-back is done
                if (!c_step && !r_cpend) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PICK: begin
                if (pick_go) begin
                    n_state = ST_DATA;
                end
            end
            ST_DATA: begin
                n_state = r_pick_last ? ST_IDLE : ST_PICK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_max_len   <= QLEN_RESET;
            r_cpend     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int l = 0; l < PRIORITY_LEVELS; l++) begin
                r_count[l] <= '0;
                r_head[l]  <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end

            // receive: grow the queue, or start the walk with its new length set
            if (rcv_ok) begin
                r_count[in_lvl] <= rcv_cmp ? rcv_keep : CNT_W'(rcv_cnt);
                r_clvl          <= in_lvl;
                r_chead         <= head_sel;
                r_keep          <= rcv_keep;
                r_ci            <= CNT_W'(1);
            end

            if (in_xfer && (in_action == ACT_SEND)) begin
                r_remain <= want_sat;
            end

            // compaction: read entry 2i now, write it to entry i next cycle
            r_cpend <= c_step;
            if (c_step) begin
                r_cwslot <= slot_add(r_chead, (SLOT_W+1)'(r_ci));
                r_ci     <= r_ci + CNT_W'(1);
            end

            // pop the head of the top level
            if (pick_go) begin
                r_head[top_lvl]  <= slot_add(head_sel, (SLOT_W+1)'(1));
                r_count[top_lvl] <= cnt_sel - CNT_W'(1);
                r_remain         <= r_remain - REM_W'(1);
                r_pick_lvl       <= top_lvl;
                r_pick_last      <= pick_last;
            end

            // output register; PICK only proceeds when it is free by now
            if (r_state == ST_DATA) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DATA) begin
            r_out_tag  <= ram_rd_data;
            r_out_prio <= PRIO_W'(r_pick_lvl);
            r_out_last <= r_pick_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_out_prio, r_out_tag});
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ----- tb/sv/spq_order_checker.sv -----
// Watches both stream channels and the cfg port, keeps its own copy of the
// per-level tag FIFOs and checks every output transfer in order.
module spq_order_checker #(
    parameter int S_DATA_W = 32,
    parameter int M_DATA_W = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_valid,
    input  logic                       i_s_ready,
    input  logic [S_DATA_W-1:0]        i_s_data,
    input  logic                       i_s_kind,
    input  logic                       i_m_valid,
    input  logic                       i_m_ready,
    input  logic [M_DATA_W-1:0]        i_m_data,
    input  logic                       i_m_last,
    input  logic                       i_cfg_wr_en,
    input  logic [spq_pkg::QLEN_W-1:0] i_cfg_wr_data,
    output int                         o_pending,
    output int                         o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVELS   = spq_pkg::DEF_PRIORITY_LEVELS;
    localparam int DEPTH    = spq_pkg::DEF_QUEUE_DEPTH;
    localparam int TAG_W    = spq_pkg::DEF_TAG_WIDTH;
    localparam int SEND_MAX = spq_pkg::DEF_MAX_SEND;
    localparam int PRIO_W   = spq_pkg::PRIO_W;
    localparam int SEND_W   = spq_pkg::SEND_W;
    localparam int CNT_W    = $clog2(DEPTH) + 1;
    localparam int HEAD_W   = $clog2(DEPTH);
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
        logic              last;
    } t_sent_pkt;

    logic [TAG_W-1:0]           tag_mem   [LEVELS][DEPTH];
    logic [CNT_W-1:0]           lvl_cnt   [LEVELS];
    logic [HEAD_W-1:0]          lvl_head  [LEVELS];
    logic [spq_pkg::QLEN_W-1:0] qlen_limit;
    t_sent_pkt                  pkt_due_q [$];
    int                         fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    function automatic int highest_busy_level();
        int lv;
        for (lv = LEVELS - 1; lv >= 0; lv--) begin
            if (lvl_cnt[lv] != 0) return lv;
        end
        return -1;
    endfunction

    function automatic void enqueue_tag(input int lvl, input logic [TAG_W-1:0] tag);
        int n;
        int h;
        int keep;
        int i;
        if (lvl >= LEVELS) return;
        if (lvl_cnt[lvl] >= DEPTH) return;
        h = lvl_head[lvl];
        tag_mem[lvl][(h + int'(lvl_cnt[lvl])) % DEPTH] = tag;
        lvl_cnt[lvl] = lvl_cnt[lvl] + 1'b1;
        if (lvl_cnt[lvl] > qlen_limit) begin
            // keep entries 1, 3, 5 ... (counted from the head), in order
            n = lvl_cnt[lvl];
            keep = (n + 1) / 2;
            for (i = 0; i < keep; i++)
                tag_mem[lvl][(h + i) % DEPTH] = tag_mem[lvl][(h + 2 * i) % DEPTH];
            lvl_cnt[lvl] = CNT_W'(keep);
        end
    endfunction

    function automatic void serve_packets(input logic [SEND_W-1:0] want_raw);
        int want;
        int sent;
        int lvl;
        t_sent_pkt pkt;
        want = want_raw;
        if (want > SEND_MAX) want = SEND_MAX;
        sent = 0;
        while (sent < want) begin
            lvl = highest_busy_level();
            if (lvl < 0) break;
            pkt.tag  = tag_mem[lvl][lvl_head[lvl]];
            pkt.prio = PRIO_W'(lvl);
            lvl_head[lvl] = HEAD_W'((int'(lvl_head[lvl]) + 1) % DEPTH);
            lvl_cnt[lvl]  = lvl_cnt[lvl] - 1'b1;
            sent++;
            // final packet of the burst: quota reached or nothing left queued
            pkt.last = (sent == want) || (highest_busy_level() < 0);
            pkt_due_q.push_back(pkt);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        int lv;
        t_sent_pkt due;
        logic [TAG_W-1:0] got_tag;
        logic [PRIO_W-1:0] got_prio;
        if (!i_rst_n) begin
            for (lv = 0; lv < LEVELS; lv++) begin
                lvl_cnt[lv]  = '0;
                lvl_head[lv] = '0;
            end
            qlen_limit = spq_pkg::QLEN_RESET;
            pkt_due_q.delete();
        end else begin
            // results leave before any item taken on this same edge can count
            if (i_m_valid && i_m_ready) begin
                got_tag  = i_m_data[TAG_W-1:0];
                got_prio = i_m_data[TAG_W+PRIO_W-1:TAG_W];
                if (pkt_due_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display("%0t: unexpected packet tag %h prio %0d last %0b",
                                 $realtime, got_tag, got_prio, i_m_last);
                end else begin
                    due = pkt_due_q.pop_front();
                    if (got_tag !== due.tag || got_prio !== due.prio
                            || i_m_last !== due.last) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX) begin
                            $write("%0t: packet mismatch: expected tag %h prio %0d last %0b",
                                   $realtime, due.tag, due.prio, due.last);
                            $display(", got tag %h prio %0d last %0b",
                                     got_tag, got_prio, i_m_last);
                        end
                    end
                end
            end
            if (i_s_valid && i_s_ready) begin
                if (i_s_kind == spq_pkg::ACT_RECEIVE)
                    enqueue_tag(int'(i_s_data[PRIO_W-1:0]), i_s_data[PRIO_W+TAG_W-1:PRIO_W]);
                else
                    serve_packets(i_s_data[PRIO_W+TAG_W+SEND_W-1:PRIO_W+TAG_W]);
            end
            if (i_cfg_wr_en)
                qlen_limit = i_cfg_wr_data;
        end
        o_pending <= pkt_due_q.size();
    end

endmodule

// ----- tb/sv/tb_strict_priority_packet_queue.sv -----
// Stimulus and verdict for the strict-priority packet queue. Order checking lives
// in spq_order_checker; this module drives transfers, watches for hangs and waits.
module tb_strict_priority_packet_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAG_W    = spq_pkg::DEF_TAG_WIDTH;
    localparam int PRIO_W   = spq_pkg::PRIO_W;
    localparam int SEND_W   = spq_pkg::SEND_W;
    localparam int S_DATA_W = ((PRIO_W + TAG_W + SEND_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((TAG_W + PRIO_W + 7) / 8) * 8;

    // Settle well past the longest compaction
    // before touching the limit register.
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_CYCLES  = 40;
    // Cycles without any transfer before the run is declared hung. The worst
    // legal quiet stretch is a long run of 85% stalls or idles plus a
    // compaction or a settle pause, far below this.
    localparam int STALL_LIMIT   = 2000;
    localparam int RAND_SEGMENTS = 9;
    localparam int SEG_ITEMS     = 38;

    logic                       i_clk     = 1'b0;
    logic                       i_rst_n   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic [S_DATA_W-1:0]        s_data    = '0;
    logic                       s_kind    = spq_pkg::ACT_RECEIVE;
    logic                       m_ready   = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [spq_pkg::QLEN_W-1:0] cfg_wr_data = '0;

    logic                       o_s_axis_tready;
    logic                       o_m_axis_tvalid;
    logic [M_DATA_W-1:0]        o_m_axis_tdata;
    logic                       o_m_axis_tlast;

    int pkts_pending;
    int fail_count;
    int quiet_cycles = 0;

    // percent of cycles the sender holds back / the receiver stalls
    int send_idle_pct = 22;
    int rcv_stall_pct = 85;

    always #4 i_clk = ~i_clk;

    strict_priority_packet_queue uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_kind),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    spq_order_checker #(
        .S_DATA_W (S_DATA_W),
        .M_DATA_W (M_DATA_W)
    ) order_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_valid     (s_valid),
        .i_s_ready     (o_s_axis_tready),
        .i_s_data      (s_data),
        .i_s_kind      (s_kind),
        .i_m_valid     (o_m_axis_tvalid),
        .i_m_ready     (m_ready),
        .i_m_data      (o_m_axis_tdata),
        .i_m_last      (o_m_axis_tlast),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_pending     (pkts_pending),
        .o_fail_count  (fail_count)
    );

    // Receiver backpressure, redrawn every cycle.
    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(99, 0) >= rcv_stall_pct);
    end

    // Hang detector: restarts on any transfer on either stream.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("strict_priority_packet_queue regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One input transfer. Entered and left just after a falling edge, so each
    // step sees exactly one update of tvalid.
    task automatic push_item(input logic kind, input logic [PRIO_W-1:0] prio,
                             input logic [TAG_W-1:0] tag, input logic [SEND_W-1:0] want);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_data  <= S_DATA_W'({want, tag, prio});
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // Receive: send_count is don't-care, so fill it with noise.
    task automatic recv_pkt(input logic [PRIO_W-1:0] prio, input logic [TAG_W-1:0] tag);
        push_item(spq_pkg::ACT_RECEIVE, prio, tag, SEND_W'($urandom_range(63, 0)));
    endtask

    // Send: priority and tag are don't-care, so fill them with noise.
    task automatic send_pkts(input logic [SEND_W-1:0] want);
        push_item(spq_pkg::ACT_SEND, PRIO_W'($urandom_range(7, 0)),
                  TAG_W'($urandom_range(65535, 0)), want);
    endtask

    // Drop tvalid, wait for every predicted packet, then let any trailing
    // compaction finish.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (pkts_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int seg;
        int k;
        int r;
        int n;
        int hot;
        int limit_plan [RAND_SEGMENTS];

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed part, limit at its reset value of 15 ----
        send_pkts(6'd5);                    // nothing queued: no packet out
        recv_pkt(3'd0, 16'h0000);
        recv_pkt(3'd7, 16'hFFFF);
        recv_pkt(3'd3, 16'hAAAA);
        recv_pkt(3'd3, 16'h5555);
        send_pkts(6'd0);                    // zero count: no packet out
        send_pkts(6'd63);                   // saturates, drains all four by priority
        // 16 arrivals on one level push it past 15 and trigger a compaction
        for (k = 0; k < 16; k++)
            recv_pkt(3'd5, 16'h1000 + k[15:0]);
        send_pkts(6'd1);
        send_pkts(6'd40);                   // above the cap, runs dry first

        // ---- random part ----
        // Limit settings include both extremes and the degenerate zero,
        // where every arrival compacts.
        limit_plan = '{1, 0, 15, 3, 15, 7, 2, 1, 0};
        limit_plan[RAND_SEGMENTS-1] = $urandom_range(15, 0);

        for (seg = 0; seg < RAND_SEGMENTS; seg++) begin
            wait_quiet();
            // idling profile: sender light/receiver heavy, then swapped, then none
            if (seg < 3) begin
                send_idle_pct = 22;
                rcv_stall_pct = 85;
            end else if (seg < 6) begin
                send_idle_pct = 85;
                rcv_stall_pct = 22;
            end else begin
                send_idle_pct = 0;
                rcv_stall_pct = 0;
            end
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= limit_plan[seg][spq_pkg::QLEN_W-1:0];
            @(negedge i_clk);
            cfg_wr_en   <= 1'b0;

            // one favored level per segment so queues grow long enough to compact
            hot = $urandom_range(7, 0);
            k = 0;
            while (k < SEG_ITEMS) begin
                r = $urandom_range(99, 0);
                if (r < 10) begin
                    // burst of arrivals on the favored level
                    n = $urandom_range(18, 8);
                    repeat (n) recv_pkt(PRIO_W'(hot), TAG_W'($urandom_range(65535, 0)));
                    k += n;
                end else if (r < 65) begin
                    if ($urandom_range(1, 0))
                        recv_pkt(PRIO_W'(hot), TAG_W'($urandom_range(65535, 0)));
                    else
                        recv_pkt(PRIO_W'($urandom_range(7, 0)),
                                 TAG_W'($urandom_range(65535, 0)));
                    k++;
                end else begin
                    r = $urandom_range(99, 0);
                    if (r < 8)
                        send_pkts(6'd0);
                    else if (r < 16)
                        send_pkts(SEND_W'($urandom_range(63, 33)));
                    else if (r < 22)
                        send_pkts(SEND_W'(spq_pkg::DEF_MAX_SEND));
                    else
                        send_pkts(SEND_W'($urandom_range(8, 1)));
                    k++;
                end
            end
        end

        // ---- wind down ----
        s_valid <= 1'b0;
        while (pkts_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pkts_pending == 0)
            $display("strict_priority_packet_queue regression: pass");
        else
            $display("strict_priority_packet_queue regression: fail");
        $finish;
    end

endmodule
